@@ rtl/core/vbd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vbd_pkg: shared types and constants of the vector beam generator
// Holds the fixed point format, queue word, divider request and response,
// command codes and the back end state encoding.
// ----------------------------------------------------------------------------
package vbd_pkg;

  // Fraction bits of the beam position.
  localparam int unsigned FracBits = 16;
  localparam int unsigned BeamW    = 48;
  // Integer coordinates plus headroom for differences.
  localparam int unsigned CoordW   = BeamW - FracBits + 2;
  // Divider geometry.
  localparam int unsigned DivSW    = CoordW;
  localparam int unsigned DivDW    = 2 * CoordW;
  localparam int unsigned ScaleQW  = FracBits + 22;
  localparam int unsigned DivQW    = (ScaleQW > CoordW) ? ScaleQW : CoordW;
  // Displacement shift before the scale division.
  localparam int unsigned ShBase   = 14 + FracBits;
  localparam logic [15:0] XShrink  = 16'd60948;
  localparam int unsigned QueueDepth = 2;

  localparam logic signed [CoordW-1:0] EdgeLo = -(CoordW'(32768));
  localparam logic signed [CoordW-1:0] EdgeHi = CoordW'(32767);
  localparam logic signed [BeamW+1:0] BeamMax = (BeamW+2)'({1'b0, {(BeamW-1){1'b1}}});
  localparam logic signed [BeamW+1:0] BeamMin = -BeamMax - (BeamW+2)'(1);

  typedef enum logic [2:0] {
    CMD_CENTER = 3'd0,
    CMD_LONG   = 3'd1,
    CMD_SHORT  = 3'd2,
    CMD_COLOR  = 3'd3,
    CMD_SCALE  = 3'd4
  } vbd_cmd_e;

  typedef enum logic [1:0] {
    OP_CENTER,
    OP_DRAW,
    OP_COLOR,
    OP_SCALE
  } vbd_op_e;

  typedef struct packed {
    vbd_op_e            op;
    logic signed [13:0] dx;
    logic signed [13:0] dy;
    logic [3:0]         intensity;
    logic [3:0]         color;
    logic [2:0]         bscale;
    logic [7:0]         lscale;
  } vbd_word_t;

  typedef struct packed {
    logic             start;
    logic [DivDW-1:0] dividend;
    logic [DivSW-1:0] divisor;
  } vbd_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DivQW-1:0] quotient;
  } vbd_div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XSTART,
    ST_XWAIT,
    ST_XMUL,
    ST_YSTART,
    ST_YWAIT,
    ST_MOVE,
    ST_TEST,
    ST_CMUL,
    ST_CSTART,
    ST_CWAIT,
    ST_EMIT
  } vbd_state_e;

  // Fixed point to integer, truncating toward zero.
  function automatic logic signed [CoordW-1:0] beam_to_coord(logic signed [BeamW-1:0] b);
    logic signed [BeamW-1:0]  sh_v;
    logic signed [CoordW-1:0] res;
    sh_v = b >>> FracBits;
    res  = CoordW'(sh_v);
    if (b[BeamW-1] && (b[FracBits-1:0] != '0)) begin
      res = res + CoordW'(1);
    end
    return res;
  endfunction

  // Saturating beam update.
  function automatic logic signed [BeamW-1:0] sat_add(logic signed [BeamW-1:0] a,
                                                      logic signed [DivQW:0] q);
    logic signed [BeamW+1:0] sum;
    sum = (BeamW+2)'(a) + (BeamW+2)'(q);
    if (sum > BeamMax) begin
      sum = BeamMax;
    end else if (sum < BeamMin) begin
      sum = BeamMin;
    end
    return sum[BeamW-1:0];
  endfunction

  function automatic logic [CoordW-1:0] cmag(logic signed [CoordW-1:0] v);
    return v[CoordW-1] ? CoordW'(-v) : CoordW'(v);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/vbd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vbd_front: command intake and queue
// Decodes each input word into an operation, doubles short draws, drops
// unknown commands and holds decoded words in a small queue.
// ----------------------------------------------------------------------------
module vbd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [2:0]       command_i,
  input  wire logic signed [12:0] dx_i,
  input  wire logic signed [12:0] dy_i,
  input  wire logic [3:0]       intensity_i,
  input  wire logic [3:0]       color_code_i,
  input  wire logic [2:0]       binary_scale_i,
  input  wire logic [7:0]       linear_scale_i,
  output logic                  word_valid_o,
  output vbd_pkg::vbd_word_t    word_o,
  input  wire logic             pop_i
);

  localparam int unsigned PtrW = (vbd_pkg::QueueDepth > 1) ? $clog2(vbd_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(vbd_pkg::QueueDepth + 1);

  vbd_pkg::vbd_word_t mem_q [vbd_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  vbd_pkg::vbd_word_t dec;
  logic known, push, pop;

  always_comb begin
    known         = 1'b1;
    dec.op        = vbd_pkg::OP_CENTER;
    dec.dx        = 14'(dx_i);
    dec.dy        = 14'(dy_i);
    dec.intensity = intensity_i;
    dec.color     = color_code_i;
    dec.bscale    = binary_scale_i;
    dec.lscale    = linear_scale_i;
    case (command_i)
      vbd_pkg::CMD_CENTER: dec.op = vbd_pkg::OP_CENTER;
      vbd_pkg::CMD_LONG:   dec.op = vbd_pkg::OP_DRAW;
      vbd_pkg::CMD_SHORT: begin
        dec.op = vbd_pkg::OP_DRAW;
        dec.dx = {dx_i, 1'b0};
        dec.dy = {dy_i, 1'b0};
      end
      vbd_pkg::CMD_COLOR:  dec.op = vbd_pkg::OP_COLOR;
      vbd_pkg::CMD_SCALE:  dec.op = vbd_pkg::OP_SCALE;
      default:             known = 1'b0;
    endcase
  end

  assign in_stall_o   = (count_q == CntW'(vbd_pkg::QueueDepth));
  assign push         = in_valid_i && !in_stall_o && known;
  assign word_valid_o = (count_q != '0);
  assign pop          = pop_i && word_valid_o;
  assign word_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(vbd_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(vbd_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= dec;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/vbd_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vbd_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; the top of the dividend
// must be below the divisor.
// ----------------------------------------------------------------------------
module vbd_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire vbd_pkg::vbd_div_req_t  req_i,
  output vbd_pkg::vbd_div_rsp_t       rsp_o
);

  localparam int unsigned QW   = vbd_pkg::DivQW;
  localparam int unsigned SW   = vbd_pkg::DivSW;
  localparam int unsigned CntW = $clog2(QW + 1);

  logic [SW-1:0]   rem_q, rem_d, dvs_q, dvs_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [SW:0]     trial;
  logic            qbit;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    qbit   = 1'b0;
    trial  = {rem_q, quo_q[QW-1]};
    if (req_i.start) begin
      rem_d  = SW'(req_i.dividend >> QW);
      quo_d  = req_i.dividend[QW-1:0];
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        qbit  = 1'b1;
        rem_d = SW'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = SW'(trial);
      end
      quo_d = {quo_q[QW-2:0], qbit};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

@@ rtl/core/vbd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vbd_back: draw execution and clipping
// Holds the beam state, scales draws through the shared divider, clips the
// line edge by edge and drives the output word register.
// ----------------------------------------------------------------------------
module vbd_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               word_valid_i,
  input  wire vbd_pkg::vbd_word_t word_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      start_x_o,
  output logic signed [15:0]      start_y_o,
  output logic signed [15:0]      end_x_o,
  output logic signed [15:0]      end_y_o,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o
);

  localparam int unsigned CW = vbd_pkg::CoordW;
  localparam int unsigned BW = vbd_pkg::BeamW;
  localparam int unsigned QW = vbd_pkg::DivQW;

  vbd_pkg::vbd_state_e state_q, state_d;
  logic signed [BW-1:0] beam_x_q, beam_x_d, beam_y_q, beam_y_d;
  logic [3:0] color_q, color_d, inten_q, inten_d;
  logic [2:0] bs_q, bs_d;
  logic [7:0] ls_q, ls_d;
  logic signed [13:0] dy_q, dy_d;
  logic neg_q, neg_d;
  logic signed [QW:0] qx_q, qx_d;
  logic [vbd_pkg::DivDW-1:0] dvd_q, dvd_d;
  logic [vbd_pkg::DivSW-1:0] dvs_q, dvs_d;
  logic signed [CW-1:0] sx_q, sx_d, sy_q, sy_d, ex_q, ex_d, ey_q, ey_d;
  logic signed [CW-1:0] diff_q, diff_d, dist_q, dist_d, span_q, span_d;
  logic pass_q, pass_d;
  logic [1:0] test_q, test_d;
  logic out_valid_q, out_valid_d;
  logic signed [15:0] osx_q, osx_d, osy_q, osy_d, oex_q, oex_d, oey_q, oey_d;
  logic [7:0] red_q, red_d, green_q, green_d, blue_q, blue_d;

  vbd_pkg::vbd_div_req_t div_req;
  vbd_pkg::vbd_div_rsp_t div_rsp;

  // Scratch values of the combinational block.
  logic [13:0] mag14;
  logic [QW+15:0] xprod;
  logic signed [QW:0] qsig;
  logic signed [CW-1:0] mov_a, mov_o, fix_a, fix_o, edge_v, qc, newc;
  logic axis, hi, out_m, out_f, adv, wr;

  vbd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    beam_x_d = beam_x_q; beam_y_d = beam_y_q;
    color_d = color_q; inten_d = inten_q; bs_d = bs_q; ls_d = ls_q;
    dy_d = dy_q; neg_d = neg_q; qx_d = qx_q; dvd_d = dvd_q; dvs_d = dvs_q;
    sx_d = sx_q; sy_d = sy_q; ex_d = ex_q; ey_d = ey_q;
    diff_d = diff_q; dist_d = dist_q; span_d = span_q;
    pass_d = pass_q; test_d = test_q;
    osx_d = osx_q; osy_d = osy_q; oex_d = oex_q; oey_d = oey_q;
    red_d = red_q; green_d = green_q; blue_d = blue_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o = 1'b0;
    div_req.start = 1'b0;
    div_req.dividend = dvd_q;
    div_req.divisor = dvs_q;
    mag14 = '0;
    xprod = '0;
    adv = 1'b0;
    wr = 1'b0;

    // Signed quotient of the divider.
    qsig = $signed({1'b0, div_rsp.quotient});
    if (neg_q) begin
      qsig = -qsig;
    end

    // Point under test: the end point in the first pass, the start point next.
    axis  = test_q[0];
    hi    = test_q[1];
    mov_a = pass_q ? (axis ? sy_q : sx_q) : (axis ? ey_q : ex_q);
    mov_o = pass_q ? (axis ? sx_q : sy_q) : (axis ? ex_q : ey_q);
    fix_a = pass_q ? (axis ? ey_q : ex_q) : (axis ? sy_q : sx_q);
    fix_o = pass_q ? (axis ? ex_q : ey_q) : (axis ? sx_q : sy_q);
    edge_v = hi ? vbd_pkg::EdgeHi : vbd_pkg::EdgeLo;
    out_m  = hi ? (mov_a > vbd_pkg::EdgeHi) : (mov_a < vbd_pkg::EdgeLo);
    out_f  = hi ? (fix_a > vbd_pkg::EdgeHi) : (fix_a < vbd_pkg::EdgeLo);
    qc = CW'(div_rsp.quotient);
    if (neg_q) begin
      qc = -qc;
    end
    newc = fix_o + qc;

    case (state_q)
      vbd_pkg::ST_IDLE: begin
        if (word_valid_i) begin
          pop_o = 1'b1;
          case (word_i.op)
            vbd_pkg::OP_CENTER: begin
              beam_x_d = '0;
              beam_y_d = '0;
            end
            vbd_pkg::OP_COLOR: color_d = word_i.color;
            vbd_pkg::OP_SCALE: begin
              bs_d = word_i.bscale;
              ls_d = word_i.lscale;
            end
            vbd_pkg::OP_DRAW: begin
              inten_d = word_i.intensity;
              dy_d    = word_i.dy;
              mag14   = word_i.dx[13] ? 14'(-word_i.dx) : 14'(word_i.dx);
              neg_d   = word_i.dx[13];
              dvd_d   = vbd_pkg::DivDW'(mag14) << (vbd_pkg::ShBase - 32'(bs_q));
              dvs_d   = vbd_pkg::DivSW'(9'd128 + 9'(ls_q));
              state_d = vbd_pkg::ST_XSTART;
            end
            default: ;
          endcase
        end
      end
      vbd_pkg::ST_XSTART: begin
        div_req.start = 1'b1;
        state_d = vbd_pkg::ST_XWAIT;
      end
      vbd_pkg::ST_XWAIT: begin
        if (div_rsp.done) begin
          state_d = vbd_pkg::ST_XMUL;
        end
      end
      vbd_pkg::ST_XMUL: begin
        xprod = (QW+16)'(div_rsp.quotient) * (QW+16)'(vbd_pkg::XShrink);
        qx_d  = $signed({1'b0, xprod[QW+15:16]});
        if (neg_q) begin
          qx_d = -$signed({1'b0, xprod[QW+15:16]});
        end
        mag14   = dy_q[13] ? 14'(-dy_q) : 14'(dy_q);
        neg_d   = dy_q[13];
        dvd_d   = vbd_pkg::DivDW'(mag14) << (vbd_pkg::ShBase - 32'(bs_q));
        state_d = vbd_pkg::ST_YSTART;
      end
      vbd_pkg::ST_YSTART: begin
        div_req.start = 1'b1;
        state_d = vbd_pkg::ST_YWAIT;
      end
      vbd_pkg::ST_YWAIT: begin
        if (div_rsp.done) begin
          state_d = vbd_pkg::ST_MOVE;
        end
      end
      vbd_pkg::ST_MOVE: begin
        beam_x_d = vbd_pkg::sat_add(beam_x_q, qx_q);
        beam_y_d = vbd_pkg::sat_add(beam_y_q, qsig);
        sx_d = vbd_pkg::beam_to_coord(beam_x_q);
        sy_d = vbd_pkg::beam_to_coord(beam_y_q);
        ex_d = vbd_pkg::beam_to_coord(beam_x_d);
        ey_d = vbd_pkg::beam_to_coord(beam_y_d);
        pass_d = 1'b0;
        test_d = '0;
        state_d = (inten_q == '0) ? vbd_pkg::ST_IDLE : vbd_pkg::ST_TEST;
      end
      vbd_pkg::ST_TEST: begin
        if (out_m) begin
          if (out_f) begin
            state_d = vbd_pkg::ST_IDLE;
          end else begin
            diff_d  = mov_o - fix_o;
            dist_d  = edge_v - fix_a;
            span_d  = mov_a - fix_a;
            state_d = vbd_pkg::ST_CMUL;
          end
        end else begin
          adv = 1'b1;
        end
      end
      vbd_pkg::ST_CMUL: begin
        dvd_d = vbd_pkg::DivDW'(vbd_pkg::cmag(diff_q)) * vbd_pkg::DivDW'(vbd_pkg::cmag(dist_q));
        dvs_d = vbd_pkg::cmag(span_q);
        neg_d = diff_q[CW-1] ^ dist_q[CW-1] ^ span_q[CW-1];
        state_d = vbd_pkg::ST_CSTART;
      end
      vbd_pkg::ST_CSTART: begin
        div_req.start = 1'b1;
        state_d = vbd_pkg::ST_CWAIT;
      end
      vbd_pkg::ST_CWAIT: begin
        if (div_rsp.done) begin
          wr  = 1'b1;
          adv = 1'b1;
        end
      end
      vbd_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          osx_d = sx_q[15:0];
          osy_d = sy_q[15:0];
          oex_d = ex_q[15:0];
          oey_d = ey_q[15:0];
          red_d   = !color_q[1] ? 8'd255 : (!color_q[0] ? 8'd128 : 8'd0);
          green_d = !color_q[3] ? 8'd255 : 8'd0;
          blue_d  = !color_q[2] ? 8'd255 : 8'd0;
          state_d = vbd_pkg::ST_IDLE;
        end
      end
      default: state_d = vbd_pkg::ST_IDLE;
    endcase

    // Move the clipped point onto the edge.
    if (wr) begin
      case ({pass_q, axis})
        2'b00: begin ex_d = edge_v; ey_d = newc; end
        2'b01: begin ey_d = edge_v; ex_d = newc; end
        2'b10: begin sx_d = edge_v; sy_d = newc; end
        2'b11: begin sy_d = edge_v; sx_d = newc; end
        default: ;
      endcase
    end

    // Step to the next edge test, the next pass or the output.
    if (adv) begin
      if (test_q == 2'd3) begin
        test_d = '0;
        if (pass_q) begin
          state_d = vbd_pkg::ST_EMIT;
        end else begin
          pass_d  = 1'b1;
          state_d = vbd_pkg::ST_TEST;
        end
      end else begin
        test_d  = test_q + 2'd1;
        state_d = vbd_pkg::ST_TEST;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vbd_pkg::ST_IDLE;
      beam_x_q    <= '0;
      beam_y_q    <= '0;
      color_q     <= '0;
      bs_q        <= '0;
      ls_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      beam_x_q    <= beam_x_d;
      beam_y_q    <= beam_y_d;
      color_q     <= color_d;
      bs_q        <= bs_d;
      ls_q        <= ls_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inten_q <= inten_d; dy_q <= dy_d; neg_q <= neg_d; qx_q <= qx_d;
    dvd_q <= dvd_d; dvs_q <= dvs_d;
    sx_q <= sx_d; sy_q <= sy_d; ex_q <= ex_d; ey_q <= ey_d;
    diff_q <= diff_d; dist_q <= dist_d; span_q <= span_d;
    pass_q <= pass_d; test_q <= test_d;
    osx_q <= osx_d; osy_q <= osy_d; oex_q <= oex_d; oey_q <= oey_d;
    red_q <= red_d; green_q <= green_d; blue_q <= blue_d;
  end

  assign out_valid_o = out_valid_q;
  assign start_x_o   = osx_q;
  assign start_y_o   = osy_q;
  assign end_x_o     = oex_q;
  assign end_y_o     = oey_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

`ifndef ASSERT_OFF
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vbd_pkg::ST_EMIT && !out_valid_q) |=> out_valid_q)
    else $error("emit state did not load the output word");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_rise_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == vbd_pkg::ST_EMIT))
    else $error("output word appeared outside the emit state");
`endif

endmodule
`default_nettype wire

@@ rtl/core/vector_beam_draw_with_clip_top.sv @@
// Back end: a draw runs the two scale divisions and one division for each clipped
// edge, at most eight, all on one shared bit-per-cycle divider; center, color and
// scale words need no division.
// Throughput: one word at a time in the back end; a two-word queue keeps intake open.
// Reset: rst_ni is asynchronous and active low; beam, color and scale clear to zero.
`default_nettype none
// ----------------------------------------------------------------------------
// vector_beam_draw_with_clip_top: vector beam generator with line clipping
// The front end decodes instruction words into a short queue; the back end
// moves the beam, clips each visible line to the 16-bit square and emits it.
// ----------------------------------------------------------------------------
module vector_beam_draw_with_clip_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         command_i,
  input  wire logic signed [12:0] dx_i,
  input  wire logic signed [12:0] dy_i,
  input  wire logic [3:0]         intensity_i,
  input  wire logic [3:0]         color_code_i,
  input  wire logic [2:0]         binary_scale_i,
  input  wire logic [7:0]         linear_scale_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      start_x_o,
  output logic signed [15:0]      start_y_o,
  output logic signed [15:0]      end_x_o,
  output logic signed [15:0]      end_y_o,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o
);

  // Decoded words travel from the front end to the back end through the queue.
  // Unknown command codes are accepted and dropped in the front end.
  vbd_pkg::vbd_word_t word;
  logic               word_valid;
  logic               pop;

  vbd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .dx_i           (dx_i),
    .dy_i           (dy_i),
    .intensity_i    (intensity_i),
    .color_code_i   (color_code_i),
    .binary_scale_i (binary_scale_i),
    .linear_scale_i (linear_scale_i),
    .word_valid_o   (word_valid),
    .word_o         (word),
    .pop_i          (pop)
  );

  // The back end holds the beam and the output word register, so a finished
  // line can wait for the consumer while the next word is being worked on.
  vbd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (word_valid),
    .word_i       (word),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .start_x_o    (start_x_o),
    .start_y_o    (start_y_o),
    .end_x_o      (end_x_o),
    .end_y_o      (end_y_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vector_beam_draw_with_clip_top
// A queue-fed driver offers instruction words and a monitor compares every
// emitted line against a behavioral beam model kept in this module.
// ----------------------------------------------------------------------------
module testbench;

  // One instruction word as the driver offers it.
  typedef struct {
    logic [2:0]         cmd;
    logic signed [12:0] dx;
    logic signed [12:0] dy;
    logic [3:0]         inten;
    logic [3:0]         color;
    logic [2:0]         bscale;
    logic [7:0]         lscale;
  } instr_t;

  // One emitted line with its color.
  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
  } line_t;

  localparam longint BeamTop = (64'sd1 <<< 47) - 1;
  localparam longint BeamBot = -BeamTop - 1;
  localparam longint Lo      = -32768;
  localparam longint Hi      = 32767;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic [2:0] command_i = '0;
  logic signed [12:0] dx_i = '0;
  logic signed [12:0] dy_i = '0;
  logic [3:0] intensity_i = '0;
  logic [3:0] color_code_i = '0;
  logic [2:0] binary_scale_i = '0;
  logic [7:0] linear_scale_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  logic signed [15:0] start_x_o;
  logic signed [15:0] start_y_o;
  logic signed [15:0] end_x_o;
  logic signed [15:0] end_y_o;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;

  vector_beam_draw_with_clip_top dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Beam model state, advanced as each word is accepted.
  longint      mdl_bx;
  longint      mdl_by;
  logic [3:0]  mdl_color;
  logic [2:0]  mdl_bscale;
  logic [7:0]  mdl_lscale;

  instr_t pending_words[$];
  line_t  lines_due[$];
  int     fail_count = 0;
  bit     calm = 1'b0;      // no random idling in the last part of the run
  bit     hold_rx = 1'b0;   // long receiver hold-off requested by the stimulus
  bit     pause_tx = 1'b0;  // sender waits while this is set
  bit     stim_done = 1'b0;

  // Exact trunc(p * a / b). Products stay well inside 128 bits of signed math.
  function automatic longint scaled_ratio(longint p, longint a, longint b);
    logic signed [127:0] num;
    num = 128'(signed'(p)) * 128'(signed'(a));
    return longint'(num / 128'(signed'(b)));
  endfunction

  // Pull point e back inside the square along the line from point s.
  function automatic bit clip_end(input longint s[2], inout longint e[2]);
    if (e[0] < Lo) begin
      if (s[0] < Lo) return 1'b0;
      e[1] = s[1] + scaled_ratio(e[1] - s[1], Lo - s[0], e[0] - s[0]);
      e[0] = Lo;
    end
    if (e[1] < Lo) begin
      if (s[1] < Lo) return 1'b0;
      e[0] = s[0] + scaled_ratio(e[0] - s[0], Lo - s[1], e[1] - s[1]);
      e[1] = Lo;
    end
    if (e[0] > Hi) begin
      if (s[0] > Hi) return 1'b0;
      e[1] = s[1] + scaled_ratio(e[1] - s[1], Hi - s[0], e[0] - s[0]);
      e[0] = Hi;
    end
    if (e[1] > Hi) begin
      if (s[1] > Hi) return 1'b0;
      e[0] = s[0] + scaled_ratio(e[0] - s[0], Hi - s[1], e[1] - s[1]);
      e[1] = Hi;
    end
    return 1'b1;
  endfunction

  function automatic longint beam_clamp(longint v);
    if (v > BeamTop) return BeamTop;
    if (v < BeamBot) return BeamBot;
    return v;
  endfunction

  // Append one word to the tail of the pending queue.
  task automatic enqueue_word(instr_t w);
    pending_words = {pending_words, w};
  endtask

  // Apply one accepted word to the model and queue the line it draws, if any.
  task automatic predict_beam(instr_t w);
    longint ddx, ddy, dv, qx, qy;
    longint s[2], e[2];
    int     sh;
    line_t  ln;
    case (w.cmd)
      vbd_pkg::CMD_CENTER: begin
        mdl_bx = 0;
        mdl_by = 0;
      end
      vbd_pkg::CMD_COLOR: mdl_color = w.color;
      vbd_pkg::CMD_SCALE: begin
        mdl_bscale = w.bscale;
        mdl_lscale = w.lscale;
      end
      vbd_pkg::CMD_LONG, vbd_pkg::CMD_SHORT: begin
        ddx = w.dx;
        ddy = w.dy;
        if (w.cmd == vbd_pkg::CMD_SHORT) begin
          ddx = ddx * 2;
          ddy = ddy * 2;
        end
        sh = 14 - int'(mdl_bscale) + int'(vbd_pkg::FracBits);
        dv = 128 + longint'(mdl_lscale);
        qx = (ddx * (64'sd1 <<< sh)) / dv;
        qx = (qx * 60948) / 65536;
        qy = (ddy * (64'sd1 <<< sh)) / dv;
        s[0] = mdl_bx / 65536;
        s[1] = mdl_by / 65536;
        mdl_bx = beam_clamp(mdl_bx + qx);
        mdl_by = beam_clamp(mdl_by + qy);
        e[0] = mdl_bx / 65536;
        e[1] = mdl_by / 65536;
        if (w.inten != 0 && clip_end(s, e) && clip_end(e, s)) begin
          ln.sx = 16'(s[0]);
          ln.sy = 16'(s[1]);
          ln.ex = 16'(e[0]);
          ln.ey = 16'(e[1]);
          ln.r  = !mdl_color[1] ? 8'd255 : (!mdl_color[0] ? 8'd128 : 8'd0);
          ln.g  = !mdl_color[3] ? 8'd255 : 8'd0;
          ln.b  = !mdl_color[2] ? 8'd255 : 8'd0;
          lines_due = {lines_due, ln};
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  // Driver: offers the head of the pending queue, with random bursts of idle.
  int tx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_beam(pending_words.pop_front());
      end
      if (in_valid_i && in_stall_o) begin
        // A stalled word stays on the bus unchanged.
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        tx_gap = $urandom_range(0, 8);
        in_valid_i <= 1'b0;
      end else if (pending_words.size() > 0 && !pause_tx) begin
        in_valid_i     <= 1'b1;
        command_i      <= pending_words[0].cmd;
        dx_i           <= pending_words[0].dx;
        dy_i           <= pending_words[0].dy;
        intensity_i    <= pending_words[0].inten;
        color_code_i   <= pending_words[0].color;
        binary_scale_i <= pending_words[0].bscale;
        linear_scale_i <= pending_words[0].lscale;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted line and drives the receiver stall.
  int rx_gap = 0;
  int hold_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_gap = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (lines_due.size() == 0) begin
          report_mismatch("line emitted with none expected");
        end else begin
          line_t x;
          x = lines_due.pop_front();
          if (start_x_o !== x.sx) report_mismatch($sformatf("start_x %0d want %0d", start_x_o, x.sx));
          if (start_y_o !== x.sy) report_mismatch($sformatf("start_y %0d want %0d", start_y_o, x.sy));
          if (end_x_o !== x.ex) report_mismatch($sformatf("end_x %0d want %0d", end_x_o, x.ex));
          if (end_y_o !== x.ey) report_mismatch($sformatf("end_y %0d want %0d", end_y_o, x.ey));
          if (red_o !== x.r) report_mismatch($sformatf("red %0d want %0d", red_o, x.r));
          if (green_o !== x.g) report_mismatch($sformatf("green %0d want %0d", green_o, x.g));
          if (blue_o !== x.b) report_mismatch($sformatf("blue %0d want %0d", blue_o, x.b));
        end
      end
      if (hold_rx && hold_left == 0) begin
        hold_left = 3000;
        hold_rx = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 8);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic instr_t mk(logic [2:0] c, int x, int y, int i, int col, int bs, int ls);
    instr_t w;
    w.cmd = c; w.dx = 13'(x); w.dy = 13'(y); w.inten = 4'(i);
    w.color = 4'(col); w.bscale = 3'(bs); w.lscale = 8'(ls);
    return w;
  endfunction

  // A random word, mostly draws with visible intensity; scale words carry
  // random binary and linear scale fields.
  function automatic instr_t rand_word();
    instr_t w;
    int     pick;
    pick = $urandom_range(0, 99);
    w = mk(vbd_pkg::CMD_LONG, $urandom, $urandom, $urandom_range(1, 15), $urandom, $urandom,
           $urandom);
    if (pick < 4) w.cmd = vbd_pkg::CMD_CENTER;
    else if (pick < 10) w.cmd = vbd_pkg::CMD_COLOR;
    else if (pick < 16) w.cmd = vbd_pkg::CMD_SCALE;
    else if (pick < 19) w.cmd = 3'($urandom_range(5, 7));
    else if (pick < 55) w.cmd = vbd_pkg::CMD_SHORT;
    if (pick >= 90) w.inten = '0;
    if ($urandom_range(0, 3) == 0) begin
      // Small moves keep lines inside the square for a while.
      w.dx = 13'($signed($urandom_range(0, 255)) - 128);
      w.dy = 13'($signed($urandom_range(0, 255)) - 128);
    end
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid_i || lines_due.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    mdl_bx = 0; mdl_by = 0; mdl_color = '0; mdl_bscale = '0; mdl_lscale = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: field extremes, every command, ignored codes, drops,
    // zero intensity and long draws at the largest scale.
    enqueue_word(mk(vbd_pkg::CMD_LONG, 100, 50, 15, 0, 0, 0));
    enqueue_word(mk(vbd_pkg::CMD_SHORT, -4096, 4095, 1, 0, 0, 0));
    enqueue_word(mk(vbd_pkg::CMD_COLOR, 0, 0, 0, 15, 0, 0));
    enqueue_word(mk(vbd_pkg::CMD_LONG, 4095, -4096, 8, 0, 0, 0));
    enqueue_word(mk(vbd_pkg::CMD_LONG, 4095, -4096, 8, 0, 0, 0));
    enqueue_word(mk(vbd_pkg::CMD_CENTER, 0, 0, 0, 0, 0, 0));
    enqueue_word(mk(vbd_pkg::CMD_SCALE, 0, 0, 0, 0, 7, 255));
    enqueue_word(mk(vbd_pkg::CMD_SHORT, -1, -1, 15, 0, 0, 0));
    enqueue_word(mk(vbd_pkg::CMD_COLOR, 0, 0, 0, 1, 0, 0));
    enqueue_word(mk(vbd_pkg::CMD_LONG, 5, -7, 4, 0, 0, 0));
    enqueue_word(mk(3'd5, 4095, 4095, 15, 15, 7, 255));
    enqueue_word(mk(3'd7, -4096, -4096, 15, 15, 7, 255));
    enqueue_word(mk(vbd_pkg::CMD_SCALE, 0, 0, 0, 0, 0, 0));
    enqueue_word(mk(vbd_pkg::CMD_COLOR, 0, 0, 0, 6, 0, 0));
    for (int k = 0; k < 8; k++)
      enqueue_word(mk(vbd_pkg::CMD_SHORT, 4095, 4095, k == 7 ? 15 : 0, 0, 0, 0));
    enqueue_word(mk(vbd_pkg::CMD_SHORT, -4096, 0, 15, 0, 0, 0));
    enqueue_word(mk(vbd_pkg::CMD_CENTER, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // Sender keeps offering while the receiver holds off a long stretch.
    hold_rx = 1'b1;
    for (int k = 0; k < 40; k++) enqueue_word(rand_word());
    wait_drained();

    // Sender pauses halfway until every expected line is in.
    for (int k = 0; k < 20; k++) enqueue_word(rand_word());
    while (pending_words.size() > 10) @(posedge clk_i);
    pause_tx = 1'b1;
    while (in_valid_i || lines_due.size() > 0) @(posedge clk_i);
    pause_tx = 1'b0;
    wait_drained();

    for (int k = 0; k < 840; k++) begin
      if (k == 700) calm = 1'b1;
      enqueue_word(rand_word());
      while (pending_words.size() > 4) @(posedge clk_i);
    end
    wait_drained();
    repeat (800) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("** vector_beam_draw_with_clip_top: PASSED **");
    end else begin
      $display("** vector_beam_draw_with_clip_top: FAILED **");
    end
    $finish;
  end

  // Worst case is roughly 900 words, each with stalls.
  initial begin
    #20ms;
    $display("** vector_beam_draw_with_clip_top: FAILED **");
    $finish;
  end

endmodule
